// File: src/sfnms_pkg.sv
// Shared types and constants of the score-filter greedy NMS block.
// No dependencies; every other file but sfnms_ram imports this package.
`timescale 1ns / 1ps
package sfnms_pkg;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register indexes on the configuration port (paddr[2])
   localparam logic REG_SCORE_THR = 1'b0;
   localparam logic REG_IOU_THR   = 1'b1;

   localparam logic [15:0] SCORE_THR_RESET = 16'd32768;
   localparam logic [15:0] IOU_THR_RESET   = 16'd26214;

   typedef struct packed {
      logic [15:0] box_x1;
      logic [15:0] box_y1;
      logic [15:0] box_x2;
      logic [15:0] box_y2;
      logic [15:0] score;
      logic [7:0]  class_index;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [15:0] det_x1;
      logic [15:0] det_y1;
      logic [15:0] det_x2;
      logic [15:0] det_y2;
      logic [15:0] det_score;
      logic [7:0]  det_class;
      logic        valid_res;
      logic        overflow;
      logic        last_out;
   } rsp_type;

   // one stored box
   typedef struct packed {
      logic [15:0] x1;
      logic [15:0] y1;
      logic [15:0] x2;
      logic [15:0] y2;
      logic [15:0] score;
      logic [7:0]  cls;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // take the input beat
      logic drop;       // store full: flag overflow
      logic ins_start;  // insertion index <= count
      logic ins_rd;     // read entry below insertion index
      logic ins_shift;  // move read entry up one slot
      logic ins_place;  // write candidate at insertion index
      logic sup_start;  // clear mask and pending survivor
      logic rd_i;       // read outer entry
      logic take_i;     // outer entry survives
      logic next_i;     // advance outer index
      logic rd_j;       // read inner entry
      logic iou_done;   // apply overlap verdict, advance inner index
      logic finish;     // emit final beat, clear set state
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic qualify;
      logic is_last;
      logic full;
      logic k_zero;
      logic rd_score_ge;
      logic i_end;
      logic i_supp;
      logic j_end;
      logic out_free;
   } sts_type;

   function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
      span16 = (hi > lo) ? (hi - lo) : 16'd0;
   endfunction

endpackage

// File: src/sfnms_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sfnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: src/sfnms_ctrl.sv
// Controller state machine: insertion sort, suppression sweep, result emission.
// Depends on sfnms_pkg.
`timescale 1ns / 1ps
module sfnms_ctrl
   import sfnms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_CHK      = 4'd1;
   localparam logic [3:0] ST_INS_TEST = 4'd2;
   localparam logic [3:0] ST_INS_WAIT = 4'd3;
   localparam logic [3:0] ST_AFTER    = 4'd4;
   localparam logic [3:0] ST_SI       = 4'd5;
   localparam logic [3:0] ST_SI_WAIT  = 4'd6;
   localparam logic [3:0] ST_SJ       = 4'd7;
   localparam logic [3:0] ST_J_WAIT   = 4'd8;
   localparam logic [3:0] ST_J1       = 4'd9;
   localparam logic [3:0] ST_J2       = 4'd10;
   localparam logic [3:0] ST_J3       = 4'd11;
   localparam logic [3:0] ST_J4       = 4'd12;
   localparam logic [3:0] ST_FIN      = 4'd13;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHK;
            end
         end
         ST_CHK: begin
            if (!sts.qualify) begin
               state_in = ST_AFTER;
            end else if (sts.full) begin
               cmd.drop = 1'b1;
               state_in = ST_AFTER;
            end else begin
               cmd.ins_start = 1'b1;
               state_in      = ST_INS_TEST;
            end
         end
         ST_INS_TEST: begin
            if (sts.k_zero) begin
               cmd.ins_place = 1'b1;
               state_in      = ST_AFTER;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = ST_INS_WAIT;
            end
         end
         ST_INS_WAIT: begin
            // equal scores stay ahead of the newcomer
            if (sts.rd_score_ge) begin
               cmd.ins_place = 1'b1;
               state_in      = ST_AFTER;
            end else begin
               cmd.ins_shift = 1'b1;
               state_in      = ST_INS_TEST;
            end
         end
         ST_AFTER: begin
            if (sts.is_last) begin
               cmd.sup_start = 1'b1;
               state_in      = ST_SI;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SI: begin
            if (sts.i_end) begin
               state_in = ST_FIN;
            end else if (sts.i_supp) begin
               cmd.next_i = 1'b1;
            end else begin
               cmd.rd_i = 1'b1;
               state_in = ST_SI_WAIT;
            end
         end
         ST_SI_WAIT: begin
            // hold until the output register can take the previous survivor
            if (sts.out_free) begin
               cmd.take_i = 1'b1;
               state_in   = ST_SJ;
            end
         end
         ST_SJ: begin
            if (sts.j_end) begin
               cmd.next_i = 1'b1;
               state_in   = ST_SI;
            end else begin
               cmd.rd_j = 1'b1;
               state_in = ST_J_WAIT;
            end
         end
         ST_J_WAIT: state_in = ST_J1;
         ST_J1:     state_in = ST_J2;
         ST_J2:     state_in = ST_J3;
         ST_J3:     state_in = ST_J4;
         ST_J4: begin
            cmd.iou_done = 1'b1;
            state_in     = ST_SJ;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: src/sfnms_dp.sv
// Datapath: candidate register, sorted box store, indexes, IoU pipeline, output register.
// Depends on sfnms_pkg and sfnms_ram.
`timescale 1ns / 1ps
module sfnms_dp
   import sfnms_pkg::*;
#(
   parameter int MAX_KEPT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_payload,
   input  logic [15:0] score_thr,
   input  logic [15:0] iou_thr,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload
);
   localparam int AW = $clog2(MAX_KEPT);
   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int EW = $bits(entry_type);

   req_type       cand_ff;
   entry_type     cand_entry;
   entry_type     rd_entry, box_ff;
   logic [EW-1:0] rdata;
   logic [CW-1:0] count_ff, i_ff, j_ff;
   logic [AW-1:0] k_ff;
   logic [MAX_KEPT-1:0] mask_ff;
   logic          ovf_ff, have_ff;
   logic          we, re;
   logic [AW-1:0] waddr, raddr;
   logic [EW-1:0] wdata;
   logic          hit;

   // IoU pipeline
   logic [15:0] wa_ff, ha_ff, wb_ff, hb_ff, iw_ff, ih_ff;
   logic [31:0] a1_ff, a2_ff, int2_ff;
   logic [32:0] uni_ff;
   logic [31:0] int3_ff, int4_ff;
   logic [48:0] prod_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   assign cand_entry = '{x1: cand_ff.box_x1, y1: cand_ff.box_y1, x2: cand_ff.box_x2,
                         y2: cand_ff.box_y2, score: cand_ff.score, cls: cand_ff.class_index};
   assign rd_entry = entry_type'(rdata);

   always_comb begin
      re    = cmd.ins_rd | cmd.rd_i | cmd.rd_j;
      raddr = k_ff - AW'(1);
      if (cmd.rd_i) begin
         raddr = i_ff[AW-1:0];
      end else if (cmd.rd_j) begin
         raddr = j_ff[AW-1:0];
      end
      we    = cmd.ins_shift | cmd.ins_place;
      waddr = k_ff;
      wdata = cmd.ins_shift ? rdata : EW'(cand_entry);
   end

   sfnms_ram #(.WIDTH(EW), .DEPTH(MAX_KEPT)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign sts.qualify     = cand_ff.score >= score_thr;
   assign sts.is_last     = cand_ff.last;
   assign sts.full        = count_ff == CW'(MAX_KEPT);
   assign sts.k_zero      = k_ff == '0;
   assign sts.rd_score_ge = rd_entry.score >= cand_ff.score;
   assign sts.i_end       = i_ff >= count_ff;
   assign sts.i_supp      = mask_ff[i_ff[AW-1:0]];
   assign sts.j_end       = j_ff >= count_ff;
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   // overlap pipeline: advance every cycle, the controller times the verdict
   always_ff @(posedge clock) begin
      wa_ff   <= span16(box_ff.x1, box_ff.x2);
      ha_ff   <= span16(box_ff.y1, box_ff.y2);
      wb_ff   <= span16(rd_entry.x1, rd_entry.x2);
      hb_ff   <= span16(rd_entry.y1, rd_entry.y2);
      iw_ff   <= span16((box_ff.x1 > rd_entry.x1) ? box_ff.x1 : rd_entry.x1,
                        (box_ff.x2 < rd_entry.x2) ? box_ff.x2 : rd_entry.x2);
      ih_ff   <= span16((box_ff.y1 > rd_entry.y1) ? box_ff.y1 : rd_entry.y1,
                        (box_ff.y2 < rd_entry.y2) ? box_ff.y2 : rd_entry.y2);
      a1_ff   <= wa_ff * ha_ff;
      a2_ff   <= wb_ff * hb_ff;
      int2_ff <= iw_ff * ih_ff;
      uni_ff  <= {1'b0, a1_ff} + {1'b0, a2_ff} - {1'b0, int2_ff};
      int3_ff <= int2_ff;
      prod_ff <= iou_thr * uni_ff;
      int4_ff <= int3_ff;
   end

   assign hit = {1'b0, int4_ff, 16'd0} > prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cand_ff <= req_payload;
      end
      if (cmd.take_i) begin
         box_ff <= rd_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         mask_ff      <= '0;
         ovf_ff       <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         if ((cmd.take_i && have_ff) || cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.drop) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.ins_start) begin
            k_ff <= count_ff[AW-1:0];
         end
         if (cmd.ins_shift) begin
            k_ff <= k_ff - AW'(1);
         end
         if (cmd.ins_place) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.sup_start) begin
            i_ff    <= '0;
            mask_ff <= '0;
            have_ff <= 1'b0;
         end
         if (cmd.next_i) begin
            i_ff <= i_ff + CW'(1);
         end
         if (cmd.take_i) begin
            j_ff    <= i_ff + CW'(1);
            have_ff <= 1'b1;
            // the pending survivor is known not to be the last one
            if (have_ff) begin
               rsp_ff <= '{det_x1: box_ff.x1, det_y1: box_ff.y1, det_x2: box_ff.x2,
                           det_y2: box_ff.y2, det_score: box_ff.score,
                           det_class: box_ff.cls, valid_res: 1'b1,
                           overflow: ovf_ff, last_out: 1'b0};
            end
         end
         if (cmd.iou_done) begin
            if (hit) begin
               mask_ff[j_ff[AW-1:0]] <= 1'b1;
            end
            j_ff <= j_ff + CW'(1);
         end
         if (cmd.finish) begin
            if (have_ff) begin
               rsp_ff <= '{det_x1: box_ff.x1, det_y1: box_ff.y1, det_x2: box_ff.x2,
                           det_y2: box_ff.y2, det_score: box_ff.score,
                           det_class: box_ff.cls, valid_res: 1'b1,
                           overflow: ovf_ff, last_out: 1'b1};
            end else begin
               rsp_ff <= '{det_x1: 16'd0, det_y1: 16'd0, det_x2: 16'd0, det_y2: 16'd0,
                           det_score: 16'd0, det_class: 8'd0, valid_res: 1'b0,
                           overflow: ovf_ff, last_out: 1'b1};
            end
            count_ff <= '0;
            ovf_ff   <= 1'b0;
            mask_ff  <= '0;
            have_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

// File: src/score_filter_greedy_nms.sv
// Top level: configuration registers, controller and datapath.
// Depends on sfnms_pkg, sfnms_ctrl, sfnms_dp.
//
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------
//  req     | req_valid/req_ready/payload    | one candidate box
//  rsp     | rsp_valid/rsp_ready/payload    | one survivor or empty marker
//  csr     | csr_psel..csr_pready           | threshold register access
//
// A rejected or dropped candidate skips the insertion walk; a kept one walks down
// the single-port-read box store from its end, moving each box of lower score up
// a slot, and stops below a box of equal or higher score or at the front.
// On the last beat the sweep skips suppressed entries, tests each survivor against
// later entries in the one shared IoU pipeline and then closes the set.
// Reset is synchronous and clears the set; no clearing pass is needed.
// A stalled result stalls the sweep only when it takes a survivor or must send
// the closing beat.
`timescale 1ns / 1ps
module score_filter_greedy_nms
   import sfnms_pkg::*;
#(
   parameter int MAX_KEPT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   logic [15:0] score_thr_ff, iou_thr_ff;
   logic        wr_en;
   cmd_type     cmd;
   sts_type     sts;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_thr_ff <= SCORE_THR_RESET;
         iou_thr_ff   <= IOU_THR_RESET;
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_SCORE_THR: score_thr_ff <= csr_pwdata[15:0];
            REG_IOU_THR:   iou_thr_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SCORE_THR: csr_prdata = {16'd0, score_thr_ff};
         REG_IOU_THR:   csr_prdata = {16'd0, iou_thr_ff};
         default:       csr_prdata = '0;
      endcase
   end

   sfnms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sfnms_dp #(.MAX_KEPT(MAX_KEPT)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .score_thr   (score_thr_ff),
      .iou_thr     (iou_thr_ff),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );
endmodule

// File: verif/sfnms_checker.sv
// Checker for the score-filter greedy NMS block: watches the box, result and
// register channels, predicts surviving boxes and compares them.
// Depends on sfnms_pkg.
`timescale 1ns / 1ps
module sfnms_checker
   import sfnms_pkg::*;
#(
   parameter int MAX_KEPT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    dets_pending,
   output int                    dets_checked,
   output int                    mismatches
);

   entry_type   kept_boxes[MAX_KEPT];
   int          kept_n;
   bit          dropped_any;
   logic [15:0] score_thr;
   logic [15:0] iou_thr;
   rsp_type     expected_dets[$];

   function automatic longint unsigned extent(input logic [15:0] lo, input logic [15:0] hi);
      return (hi > lo) ? longint'(hi - lo) : 64'd0;
   endfunction

   function automatic bit overlap_exceeds(input entry_type a, input entry_type b,
                                          input logic [15:0] thr);
      longint unsigned area_a, area_b, inter, uni;
      area_a = extent(a.x1, a.x2) * extent(a.y1, a.y2);
      area_b = extent(b.x1, b.x2) * extent(b.y1, b.y2);
      inter  = extent((a.x1 > b.x1) ? a.x1 : b.x1, (a.x2 < b.x2) ? a.x2 : b.x2)
             * extent((a.y1 > b.y1) ? a.y1 : b.y1, (a.y2 < b.y2) ? a.y2 : b.y2);
      uni    = area_a + area_b - inter;
      return (inter << 16) > (longint'(thr) * uni);
   endfunction

   // keep descending score order, later arrivals after equal scores
   task automatic store_box(input req_type b);
      int pos;
      if (kept_n >= MAX_KEPT) begin
         dropped_any = 1'b1;
         return;
      end
      pos = 0;
      while (pos < kept_n && kept_boxes[pos].score >= b.score)
         pos++;
      for (int k = kept_n; k > pos; k--)
         kept_boxes[k] = kept_boxes[k-1];
      kept_boxes[pos] = '{x1: b.box_x1, y1: b.box_y1, x2: b.box_x2, y2: b.box_y2,
                          score: b.score, cls: b.class_index};
      kept_n++;
   endtask

   task automatic sweep_set();
      bit      gone[MAX_KEPT];
      rsp_type d;
      int      n;
      n = 0;
      for (int i = 0; i < MAX_KEPT; i++)
         gone[i] = 1'b0;
      for (int i = 0; i < kept_n; i++) begin
         if (!gone[i]) begin
            d = '{det_x1: kept_boxes[i].x1, det_y1: kept_boxes[i].y1,
                  det_x2: kept_boxes[i].x2, det_y2: kept_boxes[i].y2,
                  det_score: kept_boxes[i].score, det_class: kept_boxes[i].cls,
                  valid_res: 1'b1, overflow: dropped_any, last_out: 1'b0};
            expected_dets = {expected_dets, d};
            n++;
            for (int j = i + 1; j < kept_n; j++)
               if (overlap_exceeds(kept_boxes[i], kept_boxes[j], iou_thr))
                  gone[j] = 1'b1;
         end
      end
      if (n == 0) begin
         d = '0;
         d.overflow = dropped_any;
         expected_dets = {expected_dets, d};
      end
      expected_dets[expected_dets.size()-1].last_out = 1'b1;
      kept_n      = 0;
      dropped_any = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         kept_n       = 0;
         dropped_any  = 1'b0;
         score_thr    = SCORE_THR_RESET;
         iou_thr      = IOU_THR_RESET;
         expected_dets.delete();
         dets_checked = 0;
         mismatches   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_IOU_THR)
               iou_thr = csr_pwdata[15:0];
            else
               score_thr = csr_pwdata[15:0];
         end
         if (req_valid && req_ready) begin
            if (req_payload.score >= score_thr)
               store_box(req_payload);
            if (req_payload.last)
               sweep_set();
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_dets.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t checker: unexpected result beat %p", $realtime, rsp_payload);
            end else begin
               want = expected_dets.pop_front();
               dets_checked++;
               if (rsp_payload !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t checker: result mismatch\n  expected %p\n  actual   %p",
                              $realtime, want, rsp_payload);
               end
            end
         end
      end
      dets_pending = expected_dets.size();
   end

endmodule

// File: verif/score_filter_greedy_nms_tb.sv
// Testbench top for the score-filter greedy NMS block: clock, reset, box
// stimulus, register writes, handshake idling and the verdict.
// Depends on sfnms_pkg, score_filter_greedy_nms and sfnms_checker.
`timescale 1ns / 1ps
module score_filter_greedy_nms_tb;
   import sfnms_pkg::*;

   localparam int MAX_KEPT   = 64;
   localparam int IDLE_LIMIT = 200000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int dets_pending, dets_checked, mismatches;
   int send_idle_pct, stall_pct;
   int boxes_sent, sets_sent, quiet_cycles;
   logic [15:0] cur_score_thr;

   score_filter_greedy_nms #(.MAX_KEPT(MAX_KEPT)) uut (.*);

   sfnms_checker #(.MAX_KEPT(MAX_KEPT)) checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_payload, .rsp_valid, .rsp_ready,
      .rsp_payload, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .dets_pending, .dets_checked, .mismatches);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         quiet_cycles <= 0;
      else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_box(input req_type b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (!req_ready);
      boxes_sent++;
      if (b.last)
         sets_sent++;
   endtask

   // hold off until every survivor is out and any insertion walk has finished
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (dets_pending != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(input logic reg_sel, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_sel == REG_SCORE_THR)
         cur_score_thr = value;
   endtask

   function automatic req_type mk_box(input logic [15:0] x1, y1, x2, y2, sc,
                                      input logic [7:0] cls, input logic lst);
      return '{box_x1: x1, box_y1: y1, box_x2: x2, box_y2: y2,
               score: sc, class_index: cls, last: lst};
   endfunction

   // clustered boxes overlap often; some full-range ones cover every bit
   function automatic req_type rand_box(input int cx, input int cy, input logic lst);
      req_type b;
      int pick;
      b.box_x1 = 16'(cx + $urandom_range(0, 40));
      b.box_y1 = 16'(cy + $urandom_range(0, 40));
      b.box_x2 = 16'(b.box_x1 + $urandom_range(0, 120));
      b.box_y2 = 16'(b.box_y1 + $urandom_range(0, 120));
      if ($urandom_range(0, 4) == 0) begin
         b.box_x1 = 16'($urandom());
         b.box_y1 = 16'($urandom());
         b.box_x2 = 16'($urandom());
         b.box_y2 = 16'($urandom());
      end
      pick = $urandom_range(0, 3);
      if (pick == 0)
         b.score = 16'hFFFF;
      else if (pick == 1)
         b.score = (cur_score_thr > 16'hFFF0) ? cur_score_thr
                                              : 16'(cur_score_thr + $urandom_range(0, 15));
      else
         b.score = 16'($urandom());
      b.class_index = 8'($urandom());
      b.last        = lst;
      return b;
   endfunction

   task automatic rand_set(input int n);
      int cx, cy;
      cx = $urandom_range(0, 60000);
      cy = $urandom_range(0, 60000);
      for (int k = 0; k < n; k++)
         send_box(rand_box(cx, cy, k == n - 1));
   endtask

   initial begin
      int items;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      boxes_sent    = 0;
      sets_sent     = 0;
      cur_score_thr = SCORE_THR_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset thresholds, no idling
      // full-frame box, its duplicate at exactly the threshold, two inverted boxes
      // with equal score (zero union), rejected scores, last beat itself rejected
      send_box(mk_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0));
      send_box(mk_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 8'h00, 1'b0));
      send_box(mk_box(16'd100, 16'd100, 16'd50, 16'd50, 16'hC000, 8'h01, 1'b0));
      send_box(mk_box(16'd300, 16'd10, 16'd200, 16'd400, 16'hC000, 8'h02, 1'b0));
      send_box(mk_box(16'd1, 16'd1, 16'd9, 16'd9, 16'h7FFF, 8'h03, 1'b0));
      send_box(mk_box(16'd1, 16'd1, 16'd9, 16'd9, 16'h0000, 8'h04, 1'b1));
      // empty set
      send_box(mk_box(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 8'h80, 1'b1));
      // equal scores keep arrival order; moderate overlaps on both sides of the limit
      send_box(mk_box(16'd0, 16'd0, 16'd100, 16'd100, 16'h9000, 8'h10, 1'b0));
      send_box(mk_box(16'd500, 16'd500, 16'd600, 16'd600, 16'h9000, 8'h11, 1'b0));
      send_box(mk_box(16'd20, 16'd0, 16'd120, 16'd100, 16'hA000, 8'h12, 1'b0));
      send_box(mk_box(16'd550, 16'd500, 16'd650, 16'd600, 16'h8800, 8'h13, 1'b0));
      send_box(mk_box(16'd0, 16'd0, 16'd100, 16'd100, 16'hFFFF, 8'h14, 1'b1));
      drain();

      // phases: thresholds and idling change together, extremes among them
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_reg(REG_SCORE_THR, 16'h0000);
               write_reg(REG_IOU_THR, 16'h0000);
            end
            1: begin
               write_reg(REG_SCORE_THR, 16'hFFFF);
               write_reg(REG_IOU_THR, 16'hFFFF);
            end
            2: begin
               write_reg(REG_SCORE_THR, 16'($urandom_range(16'h2000, 16'hC000)));
               write_reg(REG_IOU_THR, 16'($urandom()));
            end
            default: begin
               write_reg(REG_SCORE_THR, SCORE_THR_RESET);
               write_reg(REG_IOU_THR, IOU_THR_RESET);
            end
         endcase
         send_idle_pct = (ph == 1 || ph == 3) ? 74 : 0;
         stall_pct     = (ph == 2) ? 74 : (ph == 3) ? 38 : 0;
         if (ph == 3)
            send_idle_pct = 38;
         // every threshold kept: overfill the store once
         if (ph == 0)
            rand_set(MAX_KEPT + 4);
         items = 0;
         while (items < 20) begin
            int n;
            n = $urandom_range(1, 8);
            rand_set(n);
            items += n;
         end
         drain();
      end

      $display("tb: %0d boxes in %0d sets, %0d results checked", boxes_sent, sets_sent,
               dets_checked);
      $display("tb: thresholds swept over reset, zero, full-scale and random values");
      if (mismatches == 0 && dets_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: score_filter_greedy_nms.f
src/sfnms_pkg.sv
src/sfnms_ram.sv
src/sfnms_ctrl.sv
src/sfnms_dp.sv
src/score_filter_greedy_nms.sv
verif/sfnms_checker.sv
verif/score_filter_greedy_nms_tb.sv
